FILE: hw/rtl/deq_pkg.sv
// Shared constants and types for the double-ended queue.
// Used by the double_ended_queue top level; depends on nothing.
package deq_pkg;

    // Storage geometry.
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    // Status codes carried by a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    // Result of one operation, waiting for the store's read data.
    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
        logic             pop_ok;
    } t_pend;

endpackage

FILE: hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue: ring control around deq_ram.
// Depends on deq_pkg for geometry, codes and the pending-result type.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_op, i_value
//   result    out        o_valid / i_stall    o_removed_value, o_status, o_count_after
//
// An item is decoded in the cycle it is accepted: push data is written to the
// store then, and a pop issues its store read. The result waits in the pending
// stage for the store's registered read data, then moves into the output register.
// One item per cycle is sustained while the result side does not stall;
// a stalled result holds the pending stage, which then stalls the input.
// Reset is synchronous and active low; the store needs no clearing.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_op,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_removed_value,
    output logic [1:0]                   o_status,
    output logic [CNT_W-1:0]             o_count_after
);

    localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_I  = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0]      r_front, n_front;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_pend_valid;
    t_pend                 r_pend, n_pend;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic [1:0]            r_out_status;
    logic [CNT_W-1:0]      r_out_count;

    logic                  out_free;
    logic                  pend_move;
    logic                  accept;
    logic                  is_push;
    logic                  is_full;
    logic                  is_empty;
    logic [CNT_W:0]        sum_rear;
    logic [CNT_W:0]        sum_last;
    logic [IDX_W-1:0]      rear_next;
    logic [IDX_W-1:0]      rear_last;
    logic [IDX_W-1:0]      front_dec;
    logic [IDX_W-1:0]      front_inc;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // Handshake: the pending stage moves when the output register is free.
    assign out_free  = !r_out_valid || !i_stall;
    assign pend_move = r_pend_valid && out_free;
    assign o_stall   = r_pend_valid && !out_free;
    assign accept    = i_valid && !o_stall;

    // Ring index arithmetic; every sum stays below twice the depth.
    assign is_full   = (r_count == FULL_C);
    assign is_empty  = (r_count == '0);
    assign sum_rear  = (CNT_W + 1)'(r_front) + (CNT_W + 1)'(r_count);
    assign sum_last  = sum_rear - (CNT_W + 1)'(1);
    assign rear_next = (sum_rear >= DEPTH_S) ? IDX_W'(sum_rear - DEPTH_S) : IDX_W'(sum_rear);
    assign rear_last = (sum_last >= DEPTH_S) ? IDX_W'(sum_last - DEPTH_S) : IDX_W'(sum_last);
    assign front_dec = (r_front == '0) ? LAST_I : r_front - IDX_W'(1);
    assign front_inc = (r_front == LAST_I) ? '0 : r_front + IDX_W'(1);

    // Decode of the accepted item: store access, new ring state, pending result.
    always_comb begin
        is_push   = i_op inside {OP_PUSH_FRONT, OP_PUSH_REAR};
        n_front   = r_front;
        n_count   = r_count;
        mem_we    = 1'b0;
        mem_waddr = rear_next;
        mem_re    = 1'b0;
        mem_raddr = r_front;
        n_pend.status = ST_OK;
        n_pend.pop_ok = 1'b0;
        if (accept) begin
            if (is_push) begin
                if (is_full) begin
                    n_pend.status = ST_OVER;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (i_op == OP_PUSH_FRONT) begin
                        n_front   = front_dec;
                        mem_waddr = front_dec;
                    end
                end
            end else begin
                if (is_empty) begin
                    n_pend.status = ST_UNDER;
                end else begin
                    mem_re        = 1'b1;
                    n_pend.pop_ok = 1'b1;
                    n_count       = r_count - CNT_W'(1);
                    if (i_op == OP_POP_FRONT) begin
                        n_front = front_inc;
                    end else begin
                        mem_raddr = rear_last;
                    end
                end
            end
        end
        n_pend.count = n_count;
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Ring state and the pending stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front      <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (accept) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

    // Output register; a pop takes its value from the store's read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pend_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_value  <= r_pend.pop_ok ? mem_rdata : '0;
            r_out_status <= r_pend.status;
            r_out_count  <= r_pend.count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_out_value;
    assign o_status        = r_out_status;
    assign o_count_after   = r_out_count;

endmodule

FILE: hw/rtl/deq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; the read data holds its value between reads.
module deq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
